// ===== rtl/lge_pkg.sv =====
// Shared types and constants for the life generation engine.
`timescale 1ns / 1ps
`default_nettype none

package lge_pkg;

    localparam int CELL_W = 32;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_GEN   = 2'd2;

    localparam logic [3:0] BIRTH_COUNT  = 4'd3;
    localparam logic [3:0] SURVIVE_LOW  = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GEN
    } eng_state_t;

endpackage

`default_nettype wire

// ===== rtl/lge_grid_ram.sv =====
// One grid buffer: synchronous RAM, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lge_grid_ram #(
    parameter int DEPTH  = 600,
    parameter int ADDR_W = 10
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [ADDR_W-1:0]           waddr,
    input  wire logic [lge_pkg::CELL_W-1:0]  wdata,
    input  wire logic [ADDR_W-1:0]           raddr,
    output logic      [lge_pkg::CELL_W-1:0]  rdata
);

    logic [lge_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/lge_gen_seq.sv =====
// Generation sequencer: reads a 3x3 word window from the source grid, writes next-gen words.
`timescale 1ns / 1ps
`default_nettype none

module lge_gen_seq #(
    parameter int GRID_WIDTH  = 160,
    parameter int GRID_HEIGHT = 120
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    output logic                                         done,
    output logic [$clog2(((GRID_WIDTH + 31) / 32) * GRID_HEIGHT)-1:0] raddr,
    input  wire logic [lge_pkg::CELL_W-1:0]              rdata,
    output logic                                         we,
    output logic [$clog2(((GRID_WIDTH + 31) / 32) * GRID_HEIGHT)-1:0] waddr,
    output logic [lge_pkg::CELL_W-1:0]                   wdata
);

    localparam int WPR        = (GRID_WIDTH + 31) / 32;
    localparam int GRID_WORDS = WPR * GRID_HEIGHT;
    localparam int ADDR_W     = $clog2(GRID_WORDS);
    localparam int ROW_W      = $clog2(GRID_HEIGHT);
    localparam int COL_W      = $clog2(WPR + 1);
    localparam int LAST_BITS  = GRID_WIDTH - 32 * (WPR - 1);
    localparam logic [31:0] LAST_MASK = 32'hFFFF_FFFF << (32 - LAST_BITS);

    localparam logic [1:0] PH_ABOVE = 2'd0;
    localparam logic [1:0] PH_SAME  = 2'd1;
    localparam logic [1:0] PH_BELOW = 2'd2;

    // issue side
    logic              active_reg, active_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [1:0]        ph_reg, ph_next;
    logic [ADDR_W-1:0] base_reg, base_next;

    // return side
    logic              rv_reg;
    logic [1:0]        rph_reg;
    logic              rzero_reg;
    logic              rsrc_last_reg;
    logic              rout_last_reg;
    logic              rfirst_reg;

    logic [31:0] in_top_reg, in_mid_reg;
    logic [31:0] top_prev_reg, top_cur_reg, top_nxt_reg;
    logic [31:0] mid_prev_reg, mid_cur_reg, mid_nxt_reg;
    logic [31:0] bot_prev_reg, bot_cur_reg, bot_nxt_reg;

    logic              wb_valid_reg;
    logic              wb_last_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              done_reg;

    logic              zero_fill;
    logic              row_first, row_last, col_end;
    logic [ADDR_W-1:0] row_addr;
    logic [31:0]       rword;
    logic [31:0]       life_word;
    logic [33:0]       ext_t, ext_m, ext_b;
    logic [3:0]        ncount [32];

    assign row_first = (row_reg == '0);
    assign row_last  = (row_reg == ROW_W'(GRID_HEIGHT - 1));
    assign col_end   = (col_reg == COL_W'(WPR));
    assign zero_fill = col_end || (ph_reg == PH_ABOVE && row_first)
                       || (ph_reg == PH_BELOW && row_last);

    always_comb
    begin
        case (ph_reg)
            PH_ABOVE: row_addr = base_reg - ADDR_W'(WPR);
            PH_BELOW: row_addr = base_reg + ADDR_W'(WPR);
            default:  row_addr = base_reg;
        endcase
        raddr = zero_fill ? '0 : row_addr + ADDR_W'(col_reg);
    end

    always_comb
    begin
        active_next = active_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        ph_next     = ph_reg;
        base_next   = base_reg;
        if (start)
        begin
            active_next = 1'b1;
            row_next    = '0;
            col_next    = '0;
            ph_next     = PH_ABOVE;
            base_next   = '0;
        end
        else if (active_reg)
        begin
            if (ph_reg != PH_BELOW)
            begin
                ph_next = ph_reg + 2'd1;
            end
            else
            begin
                ph_next = PH_ABOVE;
                if (!col_end)
                begin
                    col_next = col_reg + COL_W'(1);
                end
                else
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        row_next  = row_reg + ROW_W'(1);
                        base_next = base_reg + ADDR_W'(WPR);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            ph_reg       <= PH_ABOVE;
            base_reg     <= '0;
            rv_reg       <= 1'b0;
            wb_valid_reg <= 1'b0;
            wr_addr_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            ph_reg       <= ph_next;
            base_reg     <= base_next;
            rv_reg       <= active_reg && !start;
            wb_valid_reg <= rv_reg && rph_reg == PH_BELOW && !rfirst_reg;
            done_reg     <= 1'b0;
            if (start)
            begin
                wr_addr_reg <= '0;
            end
            else if (wb_valid_reg)
            begin
                wr_addr_reg <= wr_addr_reg + ADDR_W'(1);
                done_reg    <= (wr_addr_reg == ADDR_W'(GRID_WORDS - 1));
            end
        end
    end

    assign rword = rzero_reg ? 32'h0 :
                   (rsrc_last_reg ? (rdata & LAST_MASK) : rdata);

    always_ff @(posedge clk)
    begin
        rph_reg       <= ph_reg;
        rzero_reg     <= zero_fill;
        rsrc_last_reg <= (col_reg == COL_W'(WPR - 1));
        rout_last_reg <= col_end;
        rfirst_reg    <= (col_reg == '0);
        if (start)
        begin
            top_nxt_reg <= '0;
            mid_nxt_reg <= '0;
            bot_nxt_reg <= '0;
            top_cur_reg <= '0;
            mid_cur_reg <= '0;
            bot_cur_reg <= '0;
        end
        else if (rv_reg)
        begin
            case (rph_reg)
                PH_ABOVE: in_top_reg <= rword;
                PH_SAME:  in_mid_reg <= rword;
                default:
                begin
                    top_prev_reg <= top_cur_reg;
                    top_cur_reg  <= top_nxt_reg;
                    top_nxt_reg  <= in_top_reg;
                    mid_prev_reg <= mid_cur_reg;
                    mid_cur_reg  <= mid_nxt_reg;
                    mid_nxt_reg  <= in_mid_reg;
                    bot_prev_reg <= bot_cur_reg;
                    bot_cur_reg  <= bot_nxt_reg;
                    bot_nxt_reg  <= rword;
                    wb_last_reg  <= rout_last_reg;
                end
            endcase
        end
    end

    // bit 31 is leftmost: left neighbour sits one bit up
    assign ext_t = {top_prev_reg[0], top_cur_reg, top_nxt_reg[31]};
    assign ext_m = {mid_prev_reg[0], mid_cur_reg, mid_nxt_reg[31]};
    assign ext_b = {bot_prev_reg[0], bot_cur_reg, bot_nxt_reg[31]};

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            ncount[i] = 4'(ext_t[i]) + 4'(ext_t[i+1]) + 4'(ext_t[i+2])
                      + 4'(ext_m[i]) + 4'(ext_m[i+2])
                      + 4'(ext_b[i]) + 4'(ext_b[i+1]) + 4'(ext_b[i+2]);
            if (mid_cur_reg[i])
            begin
                life_word[i] = (ncount[i] >= lge_pkg::SURVIVE_LOW)
                            && (ncount[i] <= lge_pkg::SURVIVE_HIGH);
            end
            else
            begin
                life_word[i] = (ncount[i] == lge_pkg::BIRTH_COUNT);
            end
        end
    end

    assign we    = wb_valid_reg;
    assign waddr = wr_addr_reg;
    assign wdata = wb_last_reg ? (life_word & LAST_MASK) : life_word;
    assign done  = done_reg;

endmodule

`default_nettype wire

// ===== rtl/life_generation_engine.sv =====
// Top level of the life generation engine: command decode, buffers and control.
`timescale 1ns / 1ps
`default_nettype none

// Word writes (mode 0) and reads (mode 1) are taken one per cycle while busy
// is low; each gives its result, strobed by done, in the cycle after start is
// taken, and the receiver must take it then. A generation (mode 2) holds busy
// high while the sequencer fetches each source word of the 3x3 window through
// the single read port of the current buffer; done with done_mode 2 comes in
// the cycle busy falls. After reset busy stays high while the first buffer is
// cleared.
module life_generation_engine #(
    parameter int GRID_WIDTH  = 160,
    parameter int GRID_HEIGHT = 120
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [6:0]  row,
    input  wire logic [2:0]  word_index,
    input  wire logic [31:0] data,
    output logic             done,
    output logic [31:0]      read_data,
    output logic [1:0]       done_mode
);

    localparam int WPR        = (GRID_WIDTH + 31) / 32;
    localparam int GRID_WORDS = WPR * GRID_HEIGHT;
    localparam int ADDR_W     = $clog2(GRID_WORDS);
    localparam int PROD_W     = 14;

    lge_pkg::eng_state_t state_reg, state_next;

    logic              cur_b_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              done_reg, done_next;
    logic [1:0]        done_mode_reg, done_mode_next;
    logic              rd_en_reg;
    logic              rd_b_reg;

    logic              accept;
    logic              in_grid;
    logic [PROD_W-1:0] cmd_prod;
    logic [ADDR_W-1:0] cmd_addr;
    logic              cmd_we;
    logic              clearing, generating;

    logic              seq_start, seq_done, seq_we;
    logic [ADDR_W-1:0] seq_raddr, seq_waddr;
    logic [31:0]       seq_wdata, seq_rdata;

    logic              we_a, we_b;
    logic [ADDR_W-1:0] waddr_a, waddr_b, raddr;
    logic [31:0]       wdata_a, wdata_b, rdata_a, rdata_b;

    assign accept   = start && !busy;
    assign in_grid  = (11'(row) < 11'(GRID_HEIGHT)) && (6'(word_index) < 6'(WPR));
    assign cmd_prod = PROD_W'(row) * PROD_W'(WPR) + PROD_W'(word_index);
    assign cmd_addr = in_grid ? ADDR_W'(cmd_prod) : '0;
    assign cmd_we   = accept && mode == lge_pkg::MODE_WRITE && in_grid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lge_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(GRID_WORDS - 1))
                begin
                    state_next = lge_pkg::ST_IDLE;
                end
            end
            lge_pkg::ST_IDLE:
            begin
                if (accept && mode == lge_pkg::MODE_GEN)
                begin
                    state_next = lge_pkg::ST_GEN;
                end
            end
            lge_pkg::ST_GEN:
            begin
                if (seq_done)
                begin
                    state_next = lge_pkg::ST_IDLE;
                end
            end
            default: state_next = lge_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        clearing   = 1'b0;
        generating = 1'b0;
        case (state_reg)
            lge_pkg::ST_CLEAR: clearing   = 1'b1;
            lge_pkg::ST_IDLE:  busy       = 1'b0;
            lge_pkg::ST_GEN:   generating = 1'b1;
            default:           busy       = 1'b1;
        endcase
    end

    assign seq_start = accept && mode == lge_pkg::MODE_GEN;

    always_comb
    begin
        done_next      = 1'b0;
        done_mode_next = done_mode_reg;
        if (seq_done)
        begin
            done_next      = 1'b1;
            done_mode_next = lge_pkg::MODE_GEN;
        end
        else if (accept && mode != lge_pkg::MODE_GEN)
        begin
            done_next      = 1'b1;
            done_mode_next = mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lge_pkg::ST_CLEAR;
            cur_b_reg     <= 1'b0;
            clr_addr_reg  <= '0;
            done_reg      <= 1'b0;
            done_mode_reg <= '0;
            rd_en_reg     <= 1'b0;
            rd_b_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            done_mode_reg <= done_mode_next;
            rd_en_reg     <= accept && mode == lge_pkg::MODE_READ && in_grid;
            rd_b_reg      <= cur_b_reg;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (seq_done)
            begin
                cur_b_reg <= !cur_b_reg;
            end
        end
    end

    // buffer port steering
    assign raddr = generating ? seq_raddr : cmd_addr;

    always_comb
    begin
        we_a    = cmd_we && !cur_b_reg;
        waddr_a = cmd_addr;
        wdata_a = data;
        we_b    = cmd_we && cur_b_reg;
        waddr_b = cmd_addr;
        wdata_b = data;
        if (clearing)
        begin
            we_a    = 1'b1;
            waddr_a = clr_addr_reg;
            wdata_a = '0;
        end
        else if (generating)
        begin
            we_a    = seq_we && cur_b_reg;
            waddr_a = seq_waddr;
            wdata_a = seq_wdata;
            we_b    = seq_we && !cur_b_reg;
            waddr_b = seq_waddr;
            wdata_b = seq_wdata;
        end
    end

    assign seq_rdata = cur_b_reg ? rdata_b : rdata_a;

    lge_grid_ram #(
        .DEPTH  (GRID_WORDS),
        .ADDR_W (ADDR_W)
    ) u_grid_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (wdata_a),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    lge_grid_ram #(
        .DEPTH  (GRID_WORDS),
        .ADDR_W (ADDR_W)
    ) u_grid_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (wdata_b),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    lge_gen_seq #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_gen_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq_start),
        .done  (seq_done),
        .raddr (seq_raddr),
        .rdata (seq_rdata),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata)
    );

    assign done      = done_reg;
    assign done_mode = done_mode_reg;
    assign read_data = rd_en_reg ? (rd_b_reg ? rdata_b : rdata_a) : 32'h0;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for life_generation_engine: scripted and random word commands, with a checked predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int GRID_W      = 160;
    localparam int GRID_H      = 120;
    localparam int WPR         = (GRID_W + 31) / 32;
    localparam int GRID_WORDS  = WPR * GRID_H;
    localparam int QUIET_LIMIT = 20000;
    localparam int RANDOM_WORDS = 2000;
    localparam int SCRIPT_LEN  = 25;
    localparam logic [1:0] MODE_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]  m;
        logic [6:0]  r;
        logic [2:0]  w;
        logic [31:0] d;
        logic        fixed;
        logic [31:0] rd;
    } command_t;

    typedef struct packed {
        logic [31:0] rd;
        logic [1:0]  md;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [6:0]  row;
    logic [2:0]  word_index;
    logic [31:0] data;
    logic        done;
    logic [31:0] read_data;
    logic [1:0]  done_mode;

    logic [31:0] board [2][GRID_WORDS];
    int          cur_buf;
    reply_t      awaited_replies [$];
    command_t    script [SCRIPT_LEN];
    int          issued;
    int          errors;
    int          idle_pct;
    int          quiet;

    life_generation_engine #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .row        (row),
        .word_index (word_index),
        .data       (data),
        .done       (done),
        .read_data  (read_data),
        .done_mode  (done_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit cell_alive(int s, int x, int y);
        if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H)
            return 1'b0;
        return board[s][y * WPR + (x >> 5)][31 - (x & 31)];
    endfunction

    task automatic advance_generation();
        int src;
        int dst;
        int n;
        bit alive;
        bit next;
        src = cur_buf;
        dst = 1 - cur_buf;
        for (int i = 0; i < GRID_WORDS; i++)
            board[dst][i] = '0;
        for (int y = 0; y < GRID_H; y++)
        begin
            for (int x = 0; x < GRID_W; x++)
            begin
                n = 0;
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if (dx != 0 || dy != 0)
                            n += cell_alive(src, x + dx, y + dy);
                alive = cell_alive(src, x, y);
                if (alive)
                    next = (n >= lge_pkg::SURVIVE_LOW && n <= lge_pkg::SURVIVE_HIGH);
                else
                    next = (n == lge_pkg::BIRTH_COUNT);
                if (next)
                    board[dst][y * WPR + (x >> 5)][31 - (x & 31)] = 1'b1;
            end
        end
        cur_buf = dst;
    endtask

    task automatic apply_command(input command_t c, output reply_t rep);
        bit in_grid;
        int addr;
        in_grid = (c.r < GRID_H) && (c.w < WPR);
        addr = c.r * WPR + c.w;
        rep.rd = '0;
        rep.md = c.m;
        case (c.m)
            lge_pkg::MODE_WRITE: if (in_grid) board[cur_buf][addr] = c.d;
            lge_pkg::MODE_READ:  if (in_grid) rep.rd = board[cur_buf][addr];
            lge_pkg::MODE_GEN:   advance_generation();
            default:    ;
        endcase
    endtask

    // called on a rising edge; start is left high for a following word
    task automatic issue(input command_t c);
        reply_t rep;
        mode       <= c.m;
        row        <= c.r;
        word_index <= c.w;
        data       <= c.d;
        start      <= 1'b1;
        do @(posedge clk); while (busy);
        apply_command(c, rep);
        if (c.fixed)
        begin
            rep.rd = c.rd;
            rep.md = c.m;
        end
        awaited_replies.push_back(rep);
        issued++;
    endtask

    task automatic maybe_pause();
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] cell_pattern();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom & $urandom;
            2: return $urandom & $urandom & $urandom;
            3: return 32'h1 << $urandom_range(0, 31);
            4: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom | $urandom;
        endcase
    endfunction

    function automatic logic [6:0] near_row(int focus, int spread);
        int r;
        r = focus + $urandom_range(0, 2 * spread) - spread;
        if (r < 0)
            r = 0;
        if (r > GRID_H - 1)
            r = GRID_H - 1;
        return r[6:0];
    endfunction

    function automatic command_t plain(logic [1:0] m, logic [6:0] r, logic [2:0] w,
                                       logic [31:0] d);
        return '{m: m, r: r, w: w, d: d, fixed: 1'b0, rd: 32'h0};
    endfunction

    always @(posedge clk)
    begin
        reply_t exp;
        if (rst_n && done)
        begin
            if (awaited_replies.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected word: read_data %h done_mode %0d", read_data,
                             done_mode);
                errors++;
            end
            else
            begin
                exp = awaited_replies.pop_front();
                if (read_data !== exp.rd || done_mode !== exp.md)
                begin
                    if (errors < 10)
                        $display("mismatch: read_data exp %h got %h, done_mode exp %0d got %0d",
                                 exp.rd, read_data, exp.md, done_mode);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int focus;
        int pick;
        command_t c;

        rst_n      = 1'b0;
        start      = 1'b0;
        mode       = lge_pkg::MODE_WRITE;
        row        = '0;
        word_index = '0;
        data       = '0;
        quiet      = 0;
        issued     = 0;
        errors     = 0;
        idle_pct   = 0;
        cur_buf    = 0;
        for (int i = 0; i < GRID_WORDS; i++)
        begin
            board[0][i] = '0;
            board[1][i] = '0;
        end

        script[0]  = '{lge_pkg::MODE_READ,  7'd0,   3'd0, 32'h0,         1'b1, 32'h0};
        script[1]  = '{lge_pkg::MODE_READ,  7'd119, 3'd4, 32'h0,         1'b1, 32'h0};
        script[2]  = '{lge_pkg::MODE_WRITE, 7'd0,   3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0};
        script[3]  = '{lge_pkg::MODE_READ,  7'd0,   3'd0, 32'h0,         1'b1, 32'hFFFF_FFFF};
        script[4]  = '{lge_pkg::MODE_WRITE, 7'd119, 3'd4, 32'h8000_0001, 1'b0, 32'h0};
        script[5]  = '{lge_pkg::MODE_READ,  7'd119, 3'd4, 32'h0,         1'b1, 32'h8000_0001};
        // addresses off the grid, and row 6 word 0, where row 5 word 5 would alias
        script[6]  = '{lge_pkg::MODE_WRITE, 7'd127, 3'd7, 32'hAAAA_AAAA, 1'b0, 32'h0};
        script[7]  = '{lge_pkg::MODE_READ,  7'd127, 3'd7, 32'h0,         1'b1, 32'h0};
        script[8]  = '{lge_pkg::MODE_WRITE, 7'd5,   3'd5, 32'h5555_5555, 1'b0, 32'h0};
        script[9]  = '{lge_pkg::MODE_READ,  7'd6,   3'd0, 32'h0,         1'b1, 32'h0};
        script[10] = '{lge_pkg::MODE_READ,  7'd5,   3'd5, 32'h0,         1'b1, 32'h0};
        // unused mode
        script[11] = '{MODE_NOP,            7'd3,   3'd1, 32'hDEAD_BEEF, 1'b1, 32'h0};
        // blinker, and a cluster straddling a word boundary
        script[12] = plain(lge_pkg::MODE_WRITE, 7'd10, 3'd1, 32'h0000_0E00);
        script[13] = plain(lge_pkg::MODE_WRITE, 7'd20, 3'd0, 32'h0000_0001);
        script[14] = plain(lge_pkg::MODE_WRITE, 7'd20, 3'd1, 32'hC000_0000);
        script[15] = plain(lge_pkg::MODE_WRITE, 7'd21, 3'd0, 32'h0000_0001);
        script[16] = plain(lge_pkg::MODE_GEN,   7'd0,  3'd0, 32'h0);
        script[17] = plain(lge_pkg::MODE_READ,  7'd9,  3'd1, 32'h0);
        script[18] = plain(lge_pkg::MODE_READ,  7'd10, 3'd1, 32'h0);
        script[19] = plain(lge_pkg::MODE_READ,  7'd11, 3'd1, 32'h0);
        script[20] = plain(lge_pkg::MODE_READ,  7'd0,  3'd0, 32'h0);
        script[21] = plain(lge_pkg::MODE_READ,  7'd119, 3'd4, 32'h0);
        script[22] = plain(lge_pkg::MODE_READ,  7'd20, 3'd0, 32'h0);
        script[23] = plain(lge_pkg::MODE_GEN,   7'd127, 3'd7, 32'hFFFF_FFFF);
        script[24] = plain(lge_pkg::MODE_READ,  7'd10, 3'd1, 32'h0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
            issue(script[i]);

        while (issued < SCRIPT_LEN + RANDOM_WORDS)
        begin
            focus = $urandom_range(0, GRID_H - 1);
            repeat ($urandom_range(10, 40))
            begin
                case (((issued - SCRIPT_LEN) / 250) % 4)
                    0: idle_pct = 0;
                    1: idle_pct = 64;
                    2: idle_pct = 25;
                    default: idle_pct = 0;
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    c = plain(lge_pkg::MODE_WRITE, near_row(focus, 3),
                              3'($urandom_range(0, WPR - 1)), cell_pattern());
                else if (pick < 90)
                    c = plain(lge_pkg::MODE_READ, near_row(focus, 3),
                              3'($urandom_range(0, WPR - 1)), $urandom);
                else if (pick < 96)
                    c = plain(2'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                              3'($urandom_range(0, 7)), $urandom);
                else if (pick < 99)
                    c = plain(MODE_NOP, 7'($urandom_range(0, 127)),
                              3'($urandom_range(0, 7)), $urandom);
                else
                    c = plain(lge_pkg::MODE_GEN, 7'($urandom_range(0, 127)),
                              3'($urandom_range(0, 7)), $urandom);
                issue(c);
                maybe_pause();
            end
            if ($urandom_range(0, 9) < 6)
            begin
                issue(plain(lge_pkg::MODE_GEN, 7'($urandom_range(0, 127)),
                            3'($urandom_range(0, 7)), $urandom));
                maybe_pause();
            end
            for (int dr = -2; dr <= 2; dr++)
                for (int w = 0; w < WPR; w++)
                begin
                    c = plain(lge_pkg::MODE_READ, near_row(focus + dr, 0), w[2:0], $urandom);
                    issue(c);
                    maybe_pause();
                end
        end

        start <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0 && awaited_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
